/* rtl/core/llpf_pkg.sv */
// Shared types, widths and the Cramer term table for the row peak fit.
package llpf_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int S1_W   = 24;
  localparam int S2_W   = 36;
  localparam int S3_W   = 48;
  localparam int S4_W   = 60;
  localparam int T0_W   = 20;
  localparam int T1_W   = 32;
  localparam int T2_W   = 44;
  localparam int POS_W  = 24;
  localparam int OPND_W = 60;
  localparam int ACC_W  = 112;
  localparam int DIV_W  = 136;
  localparam int QUO_W  = 23;
  localparam int NTERM  = 18;
  localparam int TERM_W = 5;

  localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
  localparam logic [POS_W-1:0] POS_MIN = 24'h800000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_row;
    logic             start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] peak_position;
    logic [ROW_W-1:0]        row_index;
    logic                    fit_valid;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] s0;
    logic [S1_W-1:0]  s1;
    logic [S2_W-1:0]  s2;
    logic [S3_W-1:0]  s3;
    logic [S4_W-1:0]  s4;
    logic [T0_W-1:0]  t0;
    logic [T1_W-1:0]  t1;
    logic [T2_W-1:0]  t2;
    logic [ROW_W-1:0] row;
  } row_sums_t;

  typedef enum logic [2:0] {
    OP_S0, OP_S1, OP_S2, OP_S3, OP_S4, OP_T0, OP_T1, OP_T2
  } op_e;

  typedef struct packed {
    op_e  a;
    op_e  b;
    op_e  c;
    logic neg;
  } term_t;

  // det terms, then b1 numerator, then b2 numerator
  localparam term_t TERM_TABLE [NTERM] = '{
    '{OP_S0, OP_S2, OP_S4, 1'b0},
    '{OP_S0, OP_S3, OP_S3, 1'b1},
    '{OP_S1, OP_S1, OP_S4, 1'b1},
    '{OP_S1, OP_S3, OP_S2, 1'b0},
    '{OP_S2, OP_S1, OP_S3, 1'b0},
    '{OP_S2, OP_S2, OP_S2, 1'b1},
    '{OP_S0, OP_T1, OP_S4, 1'b0},
    '{OP_S0, OP_S3, OP_T2, 1'b1},
    '{OP_T0, OP_S1, OP_S4, 1'b1},
    '{OP_T0, OP_S3, OP_S2, 1'b0},
    '{OP_S2, OP_S1, OP_T2, 1'b0},
    '{OP_S2, OP_T1, OP_S2, 1'b1},
    '{OP_S0, OP_S2, OP_T2, 1'b0},
    '{OP_S0, OP_T1, OP_S3, 1'b1},
    '{OP_S1, OP_S1, OP_T2, 1'b1},
    '{OP_S1, OP_T1, OP_S2, 1'b0},
    '{OP_T0, OP_S1, OP_S3, 1'b0},
    '{OP_T0, OP_S2, OP_S2, 1'b1}
  };

  localparam logic [TERM_W-1:0] TERM_LAST  = 5'd17;
  localparam logic [TERM_W-1:0] TERM_D1_LO = 5'd6;
  localparam logic [TERM_W-1:0] TERM_D2_LO = 5'd12;

endpackage

/* rtl/core/llpf_front.sv */
// Pixel intake: per-row least-squares sum accumulation and row snapshot.
module llpf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  llpf_pkg::in_item_t  in_item_i,
  output logic                sums_push_o,
  output llpf_pkg::row_sums_t sums_o,
  input  logic                sums_full_i
);
  import llpf_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_e;
  logic [IDX_W-1:0] p1_q, p1_d, p1_e;
  logic [S1_W-1:0]  p2_q, p2_d, p2_e;
  logic [S2_W-1:0]  p3_q, p3_d, p3_e;
  logic [S3_W-1:0]  p4_q, p4_d, p4_e;
  logic [ROW_W-1:0] row_q, row_d, row_e;
  row_sums_t        sums_q, sums_d, sums_e, sums_n;
  logic             accept, take;
  logic [T0_W-1:0]  ip;
  logic [T1_W-1:0]  i2p;

  assign full   = sums_full_i;
  assign accept = push && !full;

  always_comb begin
    if (in_item_i.start_of_frame) begin
      cnt_e  = '0;
      p1_e   = '0;
      p2_e   = '0;
      p3_e   = '0;
      p4_e   = '0;
      sums_e = '0;
      row_e  = '0;
    end else begin
      cnt_e  = cnt_q;
      p1_e   = p1_q;
      p2_e   = p2_q;
      p3_e   = p3_q;
      p4_e   = p4_q;
      sums_e = sums_q;
      row_e  = row_q;
    end
    take = cnt_e < CNT_W'(MAX_WIDTH);
    ip   = T0_W'(p1_e) * T0_W'(in_item_i.pixel);
    i2p  = T1_W'(p2_e) * T1_W'(in_item_i.pixel);
    sums_n     = sums_e;
    sums_n.row = row_e;
    cnt_d = cnt_e;
    p1_d  = p1_e;
    p2_d  = p2_e;
    p3_d  = p3_e;
    p4_d  = p4_e;
    if (take) begin
      sums_n.s0 = cnt_e + CNT_W'(1);
      sums_n.s1 = sums_e.s1 + S1_W'(p1_e);
      sums_n.s2 = sums_e.s2 + S2_W'(p2_e);
      sums_n.s3 = sums_e.s3 + S3_W'(p3_e);
      sums_n.s4 = sums_e.s4 + S4_W'(p4_e);
      sums_n.t0 = sums_e.t0 + T0_W'(in_item_i.pixel);
      sums_n.t1 = sums_e.t1 + T1_W'(ip);
      sums_n.t2 = sums_e.t2 + T2_W'(i2p);
      cnt_d = cnt_e + CNT_W'(1);
      p1_d  = p1_e + IDX_W'(1);
      p2_d  = p2_e + S1_W'({p1_e, 1'b0}) + S1_W'(1);
      p3_d  = p3_e + S2_W'(p2_e) * S2_W'(3) + S2_W'(p1_e) * S2_W'(3) + S2_W'(1);
      p4_d  = p4_e + S3_W'(p3_e) * S3_W'(4) + S3_W'(p2_e) * S3_W'(6)
            + S3_W'(p1_e) * S3_W'(4) + S3_W'(1);
    end
    sums_d = sums_n;
    row_d  = row_e;
    if (in_item_i.end_of_row) begin
      cnt_d  = '0;
      p1_d   = '0;
      p2_d   = '0;
      p3_d   = '0;
      p4_d   = '0;
      sums_d = '0;
      if ({1'b0, row_e} + 13'd1 >= 13'(MAX_ROWS)) begin
        row_d = '0;
      end else begin
        row_d = row_e + ROW_W'(1);
      end
    end
  end

  assign sums_push_o = accept && in_item_i.end_of_row;
  assign sums_o      = sums_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= '0;
      p4_q   <= '0;
      sums_q <= '0;
      row_q  <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
      p4_q   <= p4_d;
      sums_q <= sums_d;
      row_q  <= row_d;
    end
  end

endmodule

/* rtl/core/llpf_fifo.sv */
// Two-entry queue of row sums between intake and solver.
module llpf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  llpf_pkg::row_sums_t wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output llpf_pkg::row_sums_t rdata_o,
  output logic                empty_o
);
  import llpf_pkg::*;

  row_sums_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= !wp_q;
      end
      if (rd_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o && !rd_i))
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o))
    else $error("read from empty queue");
`endif

endmodule

/* rtl/core/llpf_back.sv */
// Solver: serial Cramer determinants, restoring divide, result register.
module llpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  llpf_pkg::row_sums_t fifo_data_i,
  output logic                fifo_pop_o,
  output logic                empty,
  input  logic                pop,
  output llpf_pkg::out_item_t out_item_o
);
  import llpf_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_MUL1 = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_ABS  = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]        state_q, state_d;
  row_sums_t         sn_q, sn_d;
  logic [TERM_W-1:0] tc_q, tc_d;
  logic [ACC_W-1:0]  mx_q, mx_d, mp_q, mp_d;
  logic [OPND_W-1:0] my_q, my_d;
  logic [ACC_W-1:0]  det_q, det_d, d1_q, d1_d, d2_q, d2_d;
  logic [DIV_W-1:0]  a_q, a_d, b_q, b_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [4:0]        k_q, k_d;
  logic              valid_q, valid_d, neg_q, neg_d, sat_q, sat_d;
  out_item_t         out_q, out_d;
  logic              ov_q, ov_d;
  term_t             term;
  logic [ACC_W-1:0]  tgt, upd, abs1, abs2;
  logic [POS_W-1:0]  pos;

  function automatic logic [OPND_W-1:0] opnd(op_e op, row_sums_t s);
    logic [OPND_W-1:0] r;
    case (op)
      OP_S0:   r = OPND_W'(s.s0);
      OP_S1:   r = OPND_W'(s.s1);
      OP_S2:   r = OPND_W'(s.s2);
      OP_S3:   r = OPND_W'(s.s3);
      OP_S4:   r = OPND_W'(s.s4);
      OP_T0:   r = OPND_W'(s.t0);
      OP_T1:   r = OPND_W'(s.t1);
      OP_T2:   r = OPND_W'(s.t2);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign term       = TERM_TABLE[tc_q];
  assign fifo_pop_o = (state_q == ST_IDLE) && !fifo_empty_i;
  assign empty      = !ov_q;
  assign out_item_o = out_q;

  always_comb begin
    if (tc_q < TERM_D1_LO) begin
      tgt = det_q;
    end else if (tc_q < TERM_D2_LO) begin
      tgt = d1_q;
    end else begin
      tgt = d2_q;
    end
    upd  = term.neg ? tgt - mp_q : tgt + mp_q;
    abs1 = d1_q[ACC_W-1] ? ~d1_q + ACC_W'(1) : d1_q;
    abs2 = d2_q[ACC_W-1] ? ~d2_q + ACC_W'(1) : d2_q;
    if (sat_q) begin
      pos = neg_q ? POS_MIN : POS_MAX;
    end else begin
      pos = neg_q ? POS_W'(0) - POS_W'(quo_q) : POS_W'(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    sn_d    = sn_q;
    tc_d    = tc_q;
    mx_d    = mx_q;
    my_d    = my_q;
    mp_d    = mp_q;
    det_d   = det_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    a_d     = a_q;
    b_d     = b_q;
    quo_d   = quo_q;
    k_d     = k_q;
    valid_d = valid_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    out_d   = out_q;
    ov_d    = ov_q && !pop;
    case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          sn_d    = fifo_data_i;
          tc_d    = '0;
          det_d   = '0;
          d1_d    = '0;
          d2_d    = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mx_d    = ACC_W'(opnd(term.a, sn_q));
        my_d    = opnd(term.b, sn_q);
        mp_d    = '0;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        if (my_q == '0) begin
          mx_d    = mp_q;
          my_d    = opnd(term.c, sn_q);
          mp_d    = '0;
          state_d = ST_MUL2;
        end else begin
          if (my_q[0]) begin
            mp_d = mp_q + mx_q;
          end
          mx_d = {mx_q[ACC_W-2:0], 1'b0};
          my_d = {1'b0, my_q[OPND_W-1:1]};
        end
      end
      ST_MUL2: begin
        if (my_q == '0) begin
          state_d = ST_ACC;
        end else begin
          if (my_q[0]) begin
            mp_d = mp_q + mx_q;
          end
          mx_d = {mx_q[ACC_W-2:0], 1'b0};
          my_d = {1'b0, my_q[OPND_W-1:1]};
        end
      end
      ST_ACC: begin
        if (tc_q < TERM_D1_LO) begin
          det_d = upd;
        end else if (tc_q < TERM_D2_LO) begin
          d1_d = upd;
        end else begin
          d2_d = upd;
        end
        if (tc_q == TERM_LAST) begin
          state_d = ST_ABS;
        end else begin
          tc_d    = tc_q + TERM_W'(1);
          state_d = ST_LOAD;
        end
      end
      ST_ABS: begin
        valid_d = (det_q != '0) && (d2_q != '0);
        neg_d   = (d1_q[ACC_W-1] == d2_q[ACC_W-1]) && (d1_q != '0);
        a_d     = DIV_W'(abs1) << 7;
        b_d     = DIV_W'(abs2) << 23;
        sat_d   = 1'b0;
        quo_d   = '0;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!valid_q) begin
          neg_d   = 1'b0;
          state_d = ST_OUT;
        end else if (a_q >= b_q) begin
          sat_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          b_d     = b_q >> 1;
          k_d     = 5'd22;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (a_q >= b_q) begin
          a_d        = a_q - b_q;
          quo_d[k_q] = 1'b1;
        end
        b_d = b_q >> 1;
        if (k_q == '0) begin
          state_d = ST_OUT;
        end else begin
          k_d = k_q - 5'd1;
        end
      end
      ST_OUT: begin
        if (!ov_q) begin
          out_d.peak_position = pos;
          out_d.row_index     = sn_q.row;
          out_d.fit_valid     = valid_q;
          ov_d                = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sn_q    <= sn_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    mp_q    <= mp_d;
    det_q   <= det_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    a_q     <= a_d;
    b_q     <= b_d;
    quo_q   <= quo_d;
    k_q     <= k_d;
    valid_q <= valid_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    out_q   <= out_d;
    tc_q    <= tc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

`ifndef SYNTHESIS
  a_div_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> valid_q)
    else $error("divide on invalid fit");
  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (tc_q <= TERM_LAST))
    else $error("term index out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |=> (state_q == ST_LOAD))
    else $error("row taken without solve start");
`endif

endmodule

/* rtl/core/laser_line_row_peak_fit_top.sv */
// Top level of the laser line row peak fit.
//
//  channel | handshake             | payload
//  input   | push / full           | in_item_i  (pixel, end_of_row, start_of_frame)
//  result  | empty / pop           | out_item_o (peak_position, row_index, fit_valid)
//
// Pixels transfer one per cycle while the row queue has room; all intake waits when
// two rows of sums are queued for the solver.
// A row solve takes 18 serial three-factor products (one shift-add per cycle,
// one step per operand bit) and then sign, compare and a 23-bit restoring divide.
// Reset is asynchronous, active low, and clears counters, sums and control.
// A result held on the output stalls the solver; pixel intake waits only once the row queue fills.
module laser_line_row_peak_fit_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  llpf_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output llpf_pkg::out_item_t out_item_o
);
  import llpf_pkg::*;

  row_sums_t sums_w, fifo_rd;
  logic      sums_push, fifo_full, fifo_empty, fifo_pop;

  llpf_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .sums_push_o(sums_push),
    .sums_o     (sums_w),
    .sums_full_i(fifo_full)
  );

  llpf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (sums_push),
    .wdata_i(sums_w),
    .full_o (fifo_full),
    .rd_i   (fifo_pop),
    .rdata_o(fifo_rd),
    .empty_o(fifo_empty)
  );

  llpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (fifo_rd),
    .fifo_pop_o  (fifo_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/tb_top.sv */
// Testbench for laser_line_row_peak_fit_top: random rows checked against a row-fit predictor.
`timescale 1ns / 100ps

module tb_top;
  import llpf_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int ROWS_MAX    = 4096;
  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 3000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t peak;
  } row_step_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  out_item_t peaks_due[$];
  int        fail_count;
  int        cycle_count;
  int        rx_hold;
  int        items_sent;
  int        peaks_seen;

  longint unsigned n_pix, s_i, s_ii, s_iii, s_iiii, s_z, s_iz, s_iiz;
  int unsigned     row_now;

  laser_line_row_peak_fit_top #(
    .MAX_WIDTH(LINE_MAX),
    .MAX_ROWS (ROWS_MAX)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic signed [255:0] triple(longint unsigned a, longint unsigned b,
                                                 longint unsigned c);
    logic [255:0] x;
    x = a;
    x = x * b;
    x = x * c;
    return x;
  endfunction

  function automatic void clear_row_sums();
    n_pix = 0; s_i = 0; s_ii = 0; s_iii = 0; s_iiii = 0;
    s_z = 0; s_iz = 0; s_iiz = 0;
  endfunction

  // accumulate one pixel; return 1 with the fitted peak at row end
  function automatic bit fit_row_peak(in_item_t it, output out_item_t pk);
    logic signed [255:0] det, d1, d2;
    logic [255:0]        m1, m2, q;
    longint unsigned     i;
    bit                  neg;
    pk = '0;
    if (it.start_of_frame) begin
      clear_row_sums();
      row_now = 0;
    end
    if (n_pix < LINE_MAX) begin
      i = n_pix;
      s_z += it.pixel;
      s_i += i;
      s_ii += i * i;
      s_iii += i * i * i;
      s_iiii += i * i * i * i;
      s_iz += i * it.pixel;
      s_iiz += i * i * it.pixel;
      n_pix++;
    end
    if (!it.end_of_row) return 0;
    det = triple(n_pix, s_ii, s_iiii) - triple(n_pix, s_iii, s_iii)
        - triple(s_i, s_i, s_iiii) + triple(s_i, s_iii, s_ii)
        + triple(s_ii, s_i, s_iii) - triple(s_ii, s_ii, s_ii);
    d1 = triple(n_pix, s_iz, s_iiii) - triple(n_pix, s_iii, s_iiz)
       - triple(s_z, s_i, s_iiii) + triple(s_z, s_iii, s_ii)
       + triple(s_ii, s_i, s_iiz) - triple(s_ii, s_iz, s_ii);
    d2 = triple(n_pix, s_ii, s_iiz) - triple(n_pix, s_iz, s_iii)
       - triple(s_i, s_i, s_iiz) + triple(s_i, s_iz, s_ii)
       + triple(s_z, s_i, s_iii) - triple(s_z, s_ii, s_ii);
    if (det != 0 && d2 != 0) begin
      neg = (d1 != 0) && ((d1 < 0) == (d2 < 0));
      m1 = (d1 < 0) ? -d1 : d1;
      m2 = (d2 < 0) ? -d2 : d2;
      q = (m1 << 7) / m2;
      if (q >= 256'd8388608) pk.peak_position = neg ? POS_MIN : POS_MAX;
      else pk.peak_position = neg ? -q[POS_W-1:0] : q[POS_W-1:0];
      pk.fit_valid = 1'b1;
    end
    pk.row_index = row_now[ROW_W-1:0];
    clear_row_sums();
    row_now = (row_now + 1 >= ROWS_MAX) ? 0 : row_now + 1;
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(in_item_t it, int gap, bit typed, out_item_t typed_peak);
    out_item_t pk;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (fit_row_peak(it, pk)) peaks_due = {peaks_due, typed ? typed_peak : pk};
  endtask

  task automatic send_row(int len, bit sof, int shape, bit fast);
    in_item_t  it;
    out_item_t none;
    int        ctr, wid, v;
    none = '0;
    ctr  = $urandom_range(0, len);
    wid  = $urandom_range(1, 40);
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: v = $urandom_range(0, 255);
        1: v = 255 - ((k - ctr) * (k - ctr) * 255) / (wid * wid);
        2: v = (k * 255) / (len > 1 ? len - 1 : 1);
        default: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
      endcase
      if (v < 0) v = $urandom_range(0, 7);
      it.pixel          = v[PIX_W-1:0];
      it.end_of_row     = (k == len - 1);
      it.start_of_frame = (k == 0 && sof) || ($urandom_range(0, 299) == 0);
      send_item(it, fast ? 0 : pick_gap(), 1'b0, none);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (peaks_due.size() == 0) begin
        $display("%0t: unexpected peak %h", $time, out_item);
        fail_count++;
      end else begin
        if (out_item.peak_position !== peaks_due[0].peak_position) begin
          $display("%0t: peak_position exp %0d got %0d", $time,
                   peaks_due[0].peak_position, out_item.peak_position);
          fail_count++;
        end
        if (out_item.row_index !== peaks_due[0].row_index) begin
          $display("%0t: row_index exp %0d got %0d", $time,
                   peaks_due[0].row_index, out_item.row_index);
          fail_count++;
        end
        if (out_item.fit_valid !== peaks_due[0].fit_valid) begin
          $display("%0t: fit_valid exp %0b got %0b", $time,
                   peaks_due[0].fit_valid, out_item.fit_valid);
          fail_count++;
        end
        void'(peaks_due.pop_front());
        peaks_seen++;
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop     <= 1'b0;
    end else begin
      pop <= (pick_gap() == 0);
    end
  end

  function automatic row_step_t step(bit [7:0] p, bit eor, bit sof, bit typed,
                                     int pos, int row, bit ok);
    row_step_t s;
    s.item  = '{pixel: p, end_of_row: eor, start_of_frame: sof};
    s.typed = typed;
    s.peak  = '{peak_position: POS_W'(pos), row_index: ROW_W'(row), fit_valid: ok};
    return s;
  endfunction

  initial begin
    row_step_t steps[$];
    int        len, shape;
    out_item_t none;

    none        = '0;
    fail_count  = 0;
    cycle_count = 0;
    rx_hold     = 0;
    items_sent  = 0;
    peaks_seen  = 0;
    push        = 1'b0;
    pop         = 1'b0;
    in_item     = '0;
    rst_ni      = 1'b0;
    clear_row_sums();
    row_now = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    steps = {steps, step(8'd255, 1, 1, 1, 0, 0, 0)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd255, 1, 0, 1, 0, 1, 0)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd255, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd0, 1, 0, 1, 256, 2, 1)};
    for (int k = 0; k < 4; k++) steps = {steps, step(8'd100, k == 3, 0, k == 3, 0, 3, 0)};
    for (int k = 0; k < 4; k++) steps = {steps, step(8'(k * 10), k == 3, 0, k == 3, 0, 4, 0)};
    steps = {steps, step(8'd255, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd255, 1, 0, 1, 256, 5, 1)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd0, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd1, 1, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd7, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd9, 0, 1, 0, 0, 0, 0)};
    steps = {steps, step(8'd3, 0, 0, 0, 0, 0, 0)};
    steps = {steps, step(8'd8, 1, 0, 0, 0, 0, 0)};
    foreach (steps[k]) send_item(steps[k].item, pick_gap(), steps[k].typed, steps[k].peak);

    push <= 1'b0;
    wait (peaks_due.size() == 0);
    @(posedge clk_i);

    rx_hold = 20000;
    for (int r = 0; r < 8; r++) send_row($urandom_range(3, 6), r == 0, 1, 1'b1);
    push <= 1'b0;
    wait (peaks_due.size() == 0);
    @(posedge clk_i);

    send_row(LINE_MAX + 6, 1'b0, 0, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      shape = $urandom_range(0, 9);
      shape = (shape < 5) ? 1 : (shape < 8) ? 0 : (shape == 8) ? 2 : 3;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
      send_row(len, $urandom_range(0, 19) == 0, shape, 1'b0);
    end
    push <= 1'b0;

    wait (peaks_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
